>>> rtl/core/ppp_pkg.sv
// Shared types, widths and helpers for the polyline point projection unit.
package ppp_pkg;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam int QUO_W = 34;   // quotient and root width
	localparam int SQ_W  = 68;   // squared distances, divisor
	localparam int NUM_W = 102;  // dividend width
	localparam int MUL_W = 35;   // multiplier operand width
	localparam int PRD_W = 70;   // product width

	localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [39:0]        edge_length;
		logic               measure_from_start;
		logic [39:0]        endpoint_offset;
		logic [31:0]        nearest_index;
		logic [31:0]        edge_id;
	} req_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [31:0] proj_x;
		logic signed [31:0] proj_y;
		logic [39:0]        along_distance;
		logic [39:0]        perp_distance;
		logic               outside_segment;
		logic [31:0]        nearest_index_out;
		logic [31:0]        edge_id_out;
	} res_t;

	function automatic logic signed [MUL_W-1:0] sdiff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return MUL_W'(a) - MUL_W'(b);
	endfunction

	function automatic logic [39:0] sat40(input logic [40:0] v);
		return v[40] ? MAX40 : v[39:0];
	endfunction

endpackage

>>> rtl/core/ppp_ram.sv
// Generic simple dual-port RAM with registered read.
module ppp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/ppp_div.sv
// Restoring divider, one quotient bit per cycle.
module ppp_div import ppp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [SQ_W-1:0]  den,
	output logic             done,
	output logic [QUO_W-1:0] quot
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [SQ_W-1:0]  rem_q, den_q;
	logic [QUO_W-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q, done_q;
	logic [SQ_W:0]    trial, diff;
	logic             ge;

	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// the low word shifts out dividend bits and shifts in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:QUO_W];
			lo_q  <= num[QUO_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
			lo_q  <= {lo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = lo_q;
endmodule

>>> rtl/core/ppp_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module ppp_isqrt import ppp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  val,
	output logic             done,
	output logic [QUO_W-1:0] root
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [SQ_W-1:0]  op_q, res_q, one_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q, done_q;
	logic [SQ_W:0]    t;
	logic             ge;

	assign t  = {1'b0, res_q} + {1'b0, one_q};
	assign ge = {1'b0, op_q} >= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= val;
			res_q <= '0;
			one_q <= SQ_W'(1) << (2 * QUO_W - 2);
		end else if (run_q) begin
			if (ge) begin
				op_q  <= op_q - t[SQ_W-1:0];
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[QUO_W-1:0];
endmodule

>>> rtl/core/polyline_point_projection_unit.sv
// Top level: point store, segment walk sequencer and shared arithmetic.
//
//  channel  | ports              | handshake
//  ---------+--------------------+-------------------------------------
//  request  | start, busy, req   | taken when start=1 and busy=0
//  result   | done, rsp          | valid for the one cycle done=1
//
// A load stores one point while the store has room. A query reads the
// point store one vertex per segment and runs each segment through one
// shared 35x35 multiplier, a bit-serial divider (two divisions) and a
// bit-serial square root; the divisions are skipped when the projection
// clamps or the segment has zero length, and two more roots finish a query.
// A query with fewer than two points answers from idle. Reset empties the
// store at once; the receiver cannot stall, so results leave as they finish.
module polyline_point_projection_unit import ppp_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t rsp
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_RDA   = 17'h00002,
		S_RDB   = 17'h00004,
		S_P1    = 17'h00008,
		S_P2    = 17'h00010,
		S_P3    = 17'h00020,
		S_CLAMP = 17'h00040,
		S_CS1   = 17'h00080,
		S_CS2   = 17'h00100,
		S_CS3   = 17'h00200,
		S_CSW   = 17'h00400,
		S_D2S   = 17'h00800,
		S_LEN   = 17'h01000,
		S_UPD   = 17'h02000,
		S_FIN   = 17'h04000,
		S_FSQ1  = 17'h08000,
		S_FSQ2  = 17'h10000
	} state_t;

	typedef enum logic [1:0] {R_AB, R_DOT, R_D2, R_FIN} ret_t;

	state_t state_q;
	ret_t   ret_q;

	logic [CW-1:0] count_q, n_q;
	logic [AW-1:0] idx_q, raddr;
	logic          we;
	logic [31:0]   rd_x, rd_y;

	logic signed [31:0] px_q, py_q, ax_q, ay_q, bx_q, by_q, qx_q, qy_q;
	logic signed [31:0] bqx_q, bqy_q, bax_q, bay_q;
	logic [39:0]        elen_q, offs_q, cum_q, bcum_q, path_q;
	logic               fs_q, out_q, bout_q, axis_q, first_q;
	logic [31:0]        nidx_q, eid_q;
	logic signed [MUL_W-1:0] abx_q, aby_q, a1_q, b1_q, a2_q, b2_q, ma, mb, dsel, mag;
	logic signed [PRD_W-1:0] mul_q, tmp_q;
	logic signed [PRD_W:0]   sum;
	logic [SQ_W-1:0]    ab2_q, d2_q, bd2_q;
	logic signed [SQ_W:0] dot_q;
	logic [QUO_W-1:0]   seglen_q;
	res_t               rsp_q;
	logic               done_q;
	logic               fin_now;

	logic             sq_start, sq_done, dv_start, dv_done;
	logic [SQ_W-1:0]  sq_in;
	logic [QUO_W-1:0] sq_root, dv_quot;
	logic [NUM_W-1:0] dv_num;
	logic signed [33:0] qstep;
	logic [40:0]      along_s;
	logic signed [42:0] along_r;
	logic [39:0]      along;

	ppp_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(req.coord_x),
		.raddr(raddr), .rdata(rd_x)
	);
	ppp_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(req.coord_y),
		.raddr(raddr), .rdata(rd_y)
	);

	ppp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(ab2_q),
		.done(dv_done), .quot(dv_quot)
	);
	ppp_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(sq_in),
		.done(sq_done), .root(sq_root)
	);

	assign we = (state_q == S_IDLE) && start && (req.req_type == REQ_LOAD)
		&& (count_q < CW'(MAX_POINTS));

	// an item finishes on a short query or when the last root is ready
	assign fin_now = ((state_q == S_IDLE) && start && (req.req_type == REQ_QUERY)
		&& (count_q < CW'(2))) || ((state_q == S_FSQ2) && sq_done);

	always_comb begin
		case (state_q)
			S_RDA:   raddr = AW'(1);
			S_UPD:   raddr = AW'(idx_q + AW'(2));
			default: raddr = '0;
		endcase
	end

	// shared multiplier operands
	assign dsel = axis_q ? aby_q : abx_q;
	assign mag  = dsel[MUL_W-1] ? -dsel : dsel;
	always_comb begin
		case (state_q)
			S_P1:    begin ma = a1_q; mb = b1_q; end
			S_P2:    begin ma = a2_q; mb = b2_q; end
			S_CS1:   begin ma = MUL_W'({1'b0, dot_q[33:0]}); mb = mag; end
			S_CS2:   begin ma = MUL_W'({1'b0, dot_q[67:34]}); mb = mag; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign sum    = PRD_W'(tmp_q) + PRD_W'(mul_q) + (PRD_W + 1)'(0);
	assign dv_num = {mul_q[SQ_W-1:0], {QUO_W{1'b0}}} + NUM_W'(tmp_q[SQ_W-1:0])
		+ NUM_W'(ab2_q[SQ_W-1:1]);
	assign dv_start = state_q == S_CS3;

	assign sq_start = ((state_q == S_P3) && (ret_q == R_D2 || ret_q == R_FIN))
		|| ((state_q == S_FSQ1) && sq_done);
	always_comb begin
		if (state_q == S_P3) begin
			sq_in = (ret_q == R_D2) ? ab2_q : sum[SQ_W-1:0];
		end else begin
			sq_in = bd2_q;
		end
	end

	// apply the signed quotient to the segment start
	assign qstep = dsel[MUL_W-1]
		? 34'(axis_q ? ay_q : ax_q) - $signed(dv_quot)
		: 34'(axis_q ? ay_q : ax_q) + $signed(dv_quot);

	assign along_s = 41'(path_q) + 41'(offs_q);
	assign along_r = 43'(elen_q) + 43'(offs_q) - 43'(path_q);
	always_comb begin
		if (fs_q) begin
			along = sat40(along_s);
		end else if (along_r[42]) begin
			along = '0;
		end else if (along_r[41:40] != 2'b00) begin
			along = MAX40;
		end else begin
			along = along_r[39:0];
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= R_AB;
			count_q <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			axis_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin_now;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.req_type == REQ_LOAD) begin
							if (we) begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							n_q     <= count_q;
							count_q <= '0;
							idx_q   <= '0;
							first_q <= 1'b1;
							if (count_q >= CW'(2)) begin
								state_q <= S_RDA;
							end
						end
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					ret_q   <= R_AB;
					state_q <= S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: begin
					case (ret_q)
						R_AB: begin
							ret_q   <= R_DOT;
							state_q <= S_P1;
						end
						R_DOT:   state_q <= S_CLAMP;
						R_D2:    state_q <= S_LEN;
						default: state_q <= S_FSQ1;
					endcase
				end
				S_CLAMP: begin
					axis_q <= 1'b0;
					if (ab2_q == '0 || dot_q[SQ_W] || dot_q > $signed({1'b0, ab2_q})) begin
						state_q <= S_D2S;
					end else begin
						state_q <= S_CS1;
					end
				end
				S_CS1: state_q <= S_CS2;
				S_CS2: state_q <= S_CS3;
				S_CS3: state_q <= S_CSW;
				S_CSW: begin
					if (dv_done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_D2S : S_CS1;
					end
				end
				S_D2S: begin
					ret_q   <= R_D2;
					state_q <= S_P1;
				end
				S_LEN: begin
					if (sq_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					first_q <= 1'b0;
					if ((CW + 1)'(idx_q) + (CW + 1)'(2) < (CW + 1)'(n_q)) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RDB;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					ret_q   <= R_FIN;
					state_q <= S_P1;
				end
				S_FSQ1: begin
					if (sq_done) begin
						state_q <= S_FSQ2;
					end
				end
				S_FSQ2: begin
					if (sq_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q   <= req.coord_x;
				py_q   <= req.coord_y;
				elen_q <= req.edge_length;
				offs_q <= req.endpoint_offset;
				fs_q   <= req.measure_from_start;
				nidx_q <= req.nearest_index;
				eid_q  <= req.edge_id;
				cum_q  <= '0;
				if (start && req.req_type == REQ_QUERY && count_q < CW'(2)) begin
					rsp_q <= '{nearest_index_out: req.nearest_index,
						edge_id_out: req.edge_id, default: '0};
				end
			end
			S_RDA: begin
				ax_q <= rd_x;
				ay_q <= rd_y;
			end
			S_RDB: begin
				bx_q  <= rd_x;
				by_q  <= rd_y;
				abx_q <= sdiff(rd_x, ax_q);
				aby_q <= sdiff(rd_y, ay_q);
				a1_q  <= sdiff(rd_x, ax_q);
				b1_q  <= sdiff(rd_x, ax_q);
				a2_q  <= sdiff(rd_y, ay_q);
				b2_q  <= sdiff(rd_y, ay_q);
			end
			S_P2: tmp_q <= mul_q;
			S_P3: begin
				case (ret_q)
					R_AB: begin
						ab2_q <= sum[SQ_W-1:0];
						a1_q  <= sdiff(px_q, ax_q);
						b1_q  <= abx_q;
						a2_q  <= sdiff(py_q, ay_q);
						b2_q  <= aby_q;
					end
					R_DOT:   dot_q <= sum[SQ_W:0];
					R_D2:    d2_q  <= sum[SQ_W-1:0];
					default: ;
				endcase
			end
			S_CLAMP: begin
				if (ab2_q != '0 && dot_q[SQ_W]) begin
					out_q <= 1'b1;
					qx_q  <= ax_q;
					qy_q  <= ay_q;
				end else if (ab2_q != '0 && dot_q > $signed({1'b0, ab2_q})) begin
					out_q <= 1'b1;
					qx_q  <= bx_q;
					qy_q  <= by_q;
				end else begin
					out_q <= 1'b0;
					qx_q  <= ax_q;
					qy_q  <= ay_q;
				end
			end
			S_CS2: tmp_q <= mul_q;
			S_CSW: begin
				if (dv_done) begin
					if (axis_q) begin
						qy_q <= qstep[31:0];
					end else begin
						qx_q <= qstep[31:0];
					end
				end
			end
			S_D2S: begin
				a1_q <= sdiff(px_q, qx_q);
				b1_q <= sdiff(px_q, qx_q);
				a2_q <= sdiff(py_q, qy_q);
				b2_q <= sdiff(py_q, qy_q);
			end
			S_LEN: begin
				if (sq_done) begin
					seglen_q <= sq_root;
				end
			end
			S_UPD: begin
				cum_q <= sat40(41'(cum_q) + 41'(seglen_q));
				if (first_q || d2_q < bd2_q) begin
					bqx_q  <= qx_q;
					bqy_q  <= qy_q;
					bax_q  <= ax_q;
					bay_q  <= ay_q;
					bout_q <= out_q;
					bd2_q  <= d2_q;
					bcum_q <= cum_q;
				end
				// advance: the end vertex starts the next segment
				ax_q <= bx_q;
				ay_q <= by_q;
			end
			S_FIN: begin
				a1_q <= sdiff(bqx_q, bax_q);
				b1_q <= sdiff(bqx_q, bax_q);
				a2_q <= sdiff(bqy_q, bay_q);
				b2_q <= sdiff(bqy_q, bay_q);
			end
			S_FSQ1: begin
				if (sq_done) begin
					path_q <= sat40(41'(bcum_q) + 41'(sq_root));
				end
			end
			S_FSQ2: begin
				if (sq_done) begin
					rsp_q.valid_res         <= 1'b1;
					rsp_q.proj_x            <= bqx_q;
					rsp_q.proj_y            <= bqy_q;
					rsp_q.along_distance    <= along;
					rsp_q.perp_distance     <= 40'(sq_root);
					rsp_q.outside_segment   <= bout_q;
					rsp_q.nearest_index_out <= nidx_q;
					rsp_q.edge_id_out       <= eid_q;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
